FILE: rtl/fesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesc_pkg
// Shared types and constants of the failure escalation window block.
// ----------------------------------------------------------------------------
package fesc_pkg;

  localparam int STATE_W       = 3;
  localparam int FAIL_LIMIT_W  = 5;
  localparam int WINDOW_W      = 16;
  localparam int WINDOW_US_W   = 36;   // 65535 s * 1e6 fits in 36 bits
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [19:0] US_PER_SEC = 20'd1000000;

  localparam logic [STATE_W-1:0] STATE_FAILED = 3'd1;

  localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_LIMIT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW     = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_RESTART  = 2'd1,
    ACT_ESCALATE = 2'd2
  } action_t;

  typedef struct packed {
    logic [FAIL_LIMIT_W-1:0] fail_limit;
    logic [WINDOW_US_W-1:0]  window_us;
    logic                    enabled;
  } cfg_t;

endpackage

FILE: rtl/failure_escalation_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failure_escalation_window_core
// Tracks state-change events and limits restart intensity: failures inside a
// sliding time window that reach a set count escalate instead of restarting.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Beat contents
//  s_*       in   s_tvalid/s_tready  new_state, now_us
//  m_*       out  m_tvalid/m_tready  prior_state, entered_state, action
//  cfg_*     in   cfg_we             register index + write data
//
//  One beat per cycle sustained. Each event passes through the input
//  register, where the decision logic runs, then, if it makes a result, sits
//  in the output register. The oldest stamp is read from the ring RAM in the
//  cycle before use, addressed from the next-state head; a same-cycle write to
//  that entry is forwarded. Reset (rst, synchronous) clears state, count, head,
//  config and valids; ring contents are left as is. A stalled m side backs up
//  to s_tready only when both registers hold a beat that makes a result.
// ----------------------------------------------------------------------------
module failure_escalation_window_core
  import fesc_pkg::*;
#(
  parameter int MAX_FAILS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [((STATE_W + TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata, // [2:0] new_state, then now_us
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [2:0] prior_state,
                                                   // [5:3] entered_state, [7:6] action
  // configuration write port
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int HEAD_W   = (MAX_FAILS > 1) ? $clog2(MAX_FAILS) : 1;
  localparam int CNT_W    = $clog2(MAX_FAILS + 1);

  // input register
  logic                    in_valid;
  logic [STATE_W-1:0]      in_state;
  logic [TIME_BITS-1:0]    in_now;

  // block state
  logic [STATE_W-1:0]      cur_state;
  logic [HEAD_W-1:0]       head;
  logic [CNT_W-1:0]        count;

  cfg_t                    cfg;
  logic [FAIL_LIMIT_W-1:0] fail_limit_next;

  // decision outputs
  logic                    has_result;
  action_t                 action;
  logic                    ring_we;
  logic [STATE_W-1:0]      cur_state_next;
  logic [HEAD_W-1:0]       head_next;
  logic [CNT_W-1:0]        count_next;
  logic [HEAD_W-1:0]       raddr;
  logic                    advance;

  // ring read path with write forwarding
  logic [TIME_BITS-1:0]    ram_rdata;
  logic                    fwd_hit;
  logic [TIME_BITS-1:0]    fwd_data;
  logic [TIME_BITS-1:0]    oldest_us;

  // output register
  logic [STATE_W-1:0]      out_prior;
  logic [STATE_W-1:0]      out_entered;
  action_t                 out_action;

  // a beat with no result never waits on the master side
  assign advance  = in_valid && (!has_result || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  fesc_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cfg             (cfg),
    .fail_limit_next (fail_limit_next)
  );

  fesc_eval #(
    .MAX_FAILS (MAX_FAILS),
    .TIME_BITS (TIME_BITS),
    .HEAD_W    (HEAD_W),
    .CNT_W     (CNT_W)
  ) u_eval (
    .advance         (advance),
    .cur_state       (cur_state),
    .req_state       (in_state),
    .now_us          (in_now),
    .head            (head),
    .count           (count),
    .cfg             (cfg),
    .fail_limit_next (fail_limit_next),
    .oldest_us       (oldest_us),
    .has_result      (has_result),
    .action          (action),
    .ring_we         (ring_we),
    .cur_state_next  (cur_state_next),
    .head_next       (head_next),
    .count_next      (count_next),
    .raddr           (raddr)
  );

  fesc_ram #(
    .WIDTH  (TIME_BITS),
    .DEPTH  (MAX_FAILS),
    .ADDR_W (HEAD_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head),
    .wdata (in_now),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // RAM returns old data on a same-address write; take the new stamp instead
  always_ff @(posedge clk) begin
    fwd_hit  <= ring_we && (head == raddr);
    fwd_data <= in_now;
  end

  assign oldest_us = fwd_hit ? fwd_data : ram_rdata;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_state <= s_tdata[STATE_W-1:0];
      in_now   <= s_tdata[STATE_W +: TIME_BITS];
    end
  end

  // state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      head      <= '0;
      count     <= '0;
    end else begin
      cur_state <= cur_state_next;
      head      <= head_next;
      count     <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && has_result) begin
      out_prior   <= cur_state;
      out_entered <= in_state;
      out_action  <= action;
    end
  end

  assign m_tdata = {out_action, out_entered, out_prior};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_change_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_prior != out_entered))
    else $error("result beat without a state change");

  a_action_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_action != ACT_NONE) |-> (out_entered == STATE_FAILED))
    else $error("restart or escalate on a non-failed state");

  a_esc_clear: assert property (@(posedge clk) disable iff (rst)
    advance && has_result && (action == ACT_ESCALATE) |=> (count == '0) && (head == '0))
    else $error("ring not cleared after escalation");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_FAILS))
    else $error("stamp count beyond ring depth");

  a_ring_hold: assert property (@(posedge clk) disable iff (rst)
    !ring_we |=> (head == $past(head)) && (count == $past(count)))
    else $error("ring pointers moved without a push or escalation");

endmodule

FILE: rtl/fesc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fesc_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fesc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesc_cfg
// Configuration registers; the window is kept pre-scaled to microseconds.
// ----------------------------------------------------------------------------
module fesc_cfg
  import fesc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output cfg_t                    cfg,
  output logic [FAIL_LIMIT_W-1:0] fail_limit_next
);

  logic [FAIL_LIMIT_W-1:0] fail_limit;
  logic [WINDOW_US_W-1:0]  window_us;
  logic                    window_nz;

  always_comb begin
    fail_limit_next = fail_limit;
    if (cfg_we && (cfg_index == CFG_FAIL_LIMIT)) begin
      fail_limit_next = cfg_wdata[FAIL_LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit <= '0;
      window_us  <= '0;
      window_nz  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAIL_LIMIT: fail_limit <= cfg_wdata[FAIL_LIMIT_W-1:0];
        CFG_WINDOW: begin
          window_us <= WINDOW_US_W'(cfg_wdata[WINDOW_W-1:0]) * WINDOW_US_W'(US_PER_SEC);
          window_nz <= (cfg_wdata[WINDOW_W-1:0] != '0);
        end
        default: ;
      endcase
    end
  end

  assign cfg.fail_limit = fail_limit;
  assign cfg.window_us  = window_us;
  assign cfg.enabled    = (fail_limit != '0) && window_nz;

endmodule

FILE: rtl/fesc_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesc_eval
// Per-event decision: state change, ring push, window test, next state and
// the ring read address for the following event.
// ----------------------------------------------------------------------------
module fesc_eval
  import fesc_pkg::*;
#(
  parameter int MAX_FAILS = 16,
  parameter int TIME_BITS = 48,
  parameter int HEAD_W    = (MAX_FAILS > 1) ? $clog2(MAX_FAILS) : 1,
  parameter int CNT_W     = $clog2(MAX_FAILS + 1)
) (
  input  logic                    advance,
  input  logic [STATE_W-1:0]      cur_state,
  input  logic [STATE_W-1:0]      req_state,
  input  logic [TIME_BITS-1:0]    now_us,
  input  logic [HEAD_W-1:0]       head,
  input  logic [CNT_W-1:0]        count,
  input  cfg_t                    cfg,
  input  logic [FAIL_LIMIT_W-1:0] fail_limit_next,
  input  logic [TIME_BITS-1:0]    oldest_us,
  output logic                    has_result,
  output action_t                 action,
  output logic                    ring_we,
  output logic [STATE_W-1:0]      cur_state_next,
  output logic [HEAD_W-1:0]       head_next,
  output logic [CNT_W-1:0]        count_next,
  output logic [HEAD_W-1:0]       raddr
);

  localparam int LIM_W = (FAIL_LIMIT_W > CNT_W) ? FAIL_LIMIT_W : CNT_W;
  localparam int CMP_W = (TIME_BITS > WINDOW_US_W) ? TIME_BITS : WINDOW_US_W;
  localparam int SUM_W = CNT_W + 1;

  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    return (h == HEAD_W'(MAX_FAILS - 1)) ? '0 : HEAD_W'(h + 1'b1);
  endfunction

  function automatic logic [CNT_W-1:0] lim_sat(input logic [FAIL_LIMIT_W-1:0] fl);
    logic [LIM_W-1:0] x;
    x = LIM_W'(fl);
    return (x > LIM_W'(MAX_FAILS)) ? CNT_W'(MAX_FAILS) : CNT_W'(x);
  endfunction

  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     lim_n;
  logic                 change;
  logic                 is_fail;
  logic                 push;
  logic [CNT_W-1:0]     count_inc;
  logic [TIME_BITS-1:0] oldest_sel;
  logic [TIME_BITS-1:0] span;
  logic                 in_window;
  logic                 escalate;
  logic [HEAD_W-1:0]    head_sel;
  logic [SUM_W-1:0]     idx_sum;

  assign lim     = lim_sat(cfg.fail_limit);
  assign lim_n   = lim_sat(fail_limit_next);
  assign change  = (req_state != cur_state);
  assign is_fail = (req_state == STATE_FAILED);
  assign push    = change && is_fail && cfg.enabled;

  assign count_inc = (count < CNT_W'(MAX_FAILS)) ? CNT_W'(count + 1'b1) : count;

  // limit of one compares the new stamp with itself
  assign oldest_sel = (lim == CNT_W'(1)) ? now_us : oldest_us;
  assign span       = now_us - oldest_sel;
  assign in_window  = (CMP_W'(span) <= CMP_W'(cfg.window_us));
  assign escalate   = push && (count_inc >= lim) && in_window;

  always_comb begin
    if (!change || !is_fail) begin
      action = ACT_NONE;
    end else if (escalate) begin
      action = ACT_ESCALATE;
    end else begin
      action = ACT_RESTART;
    end
  end

  assign has_result = change;
  assign ring_we    = advance && push;

  always_comb begin
    cur_state_next = cur_state;
    head_next      = head;
    count_next     = count;
    if (advance && change) begin
      cur_state_next = req_state;
      if (push) begin
        head_next  = escalate ? '0 : head_inc(head);
        count_next = escalate ? '0 : count_inc;
      end
    end
  end

  // oldest entry the next event will need: (head after its push) - limit
  assign head_sel = head_next;
  assign idx_sum  = SUM_W'(head_inc(head_sel)) + SUM_W'(MAX_FAILS) - SUM_W'(lim_n);
  assign raddr    = (idx_sum >= SUM_W'(MAX_FAILS)) ? HEAD_W'(idx_sum - SUM_W'(MAX_FAILS))
                                                   : HEAD_W'(idx_sum);

endmodule
